// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL in this folder.
// Each macro samples on posedge clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/soa_pkg.sv =====
// Shared types and constants for the slab object allocator.
// No dependencies.
`timescale 1ns / 1ps

package soa_pkg;

  localparam int CLS_W       = 3;
  localparam int MAX_CLASSES = 8;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NOT_OWNED = 2'd3
  } status_t;

  // Object size of a class: 16 bytes doubled per class step.
  function automatic logic [11:0] class_bytes(input logic [CLS_W-1:0] c);
    return 12'd16 << c;
  endfunction

endpackage

// ===== rtl/core/soa_class_decode.sv =====
// Size-to-class decode for the slab object allocator.
// Depends on soa_pkg.
`timescale 1ns / 1ps

module soa_class_decode import soa_pkg::*; #(
  parameter int NUM_CLASSES = 8
) (
  input  logic [31:0]      size,
  input  logic [11:0]      max_obj_size,
  output logic [CLS_W-1:0] cls,
  output logic             bad
);

  logic found;

  // Scan from the top so the smallest covering class wins.
  always_comb begin
    found = 1'b0;
    cls   = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (size <= 32'(class_bytes(CLS_W'(i)))) begin
        cls   = CLS_W'(i);
        found = 1'b1;
      end
    end
    bad = (size == 32'd0) || (size > 32'(max_obj_size)) || !found;
  end

endmodule

// ===== rtl/core/slab_object_allocator_unit.sv =====
// Slab object allocator top level: request sequencer, page metadata and free-stack memories.
// Depends on soa_pkg, soa_class_decode and assert_macros.svh.
`timescale 1ns / 1ps

// One request is taken at a time and gives exactly one result beat. Page
// metadata (next link, class, free count, low-water mark) lives in one
// synchronous RAM, per-page free stacks in a second; both reads are
// registered. An ownership query, bad size, exhausted pool or no-op goes
// from decode to the result; a free adds the free step; an alloc adds the
// address step, after the metadata read on a partial page, chained with the
// free-stack read for a pushed-back object. The result sits in an
// output register, so a stalled result delays only the next finished one.
// Nothing is cleared after reset: a page's metadata is written when the page
// is claimed, and stack slots under the low-water mark are never read.
module slab_object_allocator_unit import soa_pkg::*; #(
  parameter int NUM_CLASSES  = 8,
  parameter int PAGE_BYTES   = 4096,
  parameter int POOL_PAGES   = 64,
  parameter int HEADER_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] req_size,
  input  logic [31:0] req_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_addr,
  output logic [1:0]  status,
  output logic        owned
);

`include "assert_macros.svh"

  localparam int PSH    = $clog2(PAGE_BYTES);
  localparam int SLOTS  = PAGE_BYTES / 16;
  localparam int CNT_W  = $clog2(SLOTS);
  localparam int PG_W   = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int ISS_W  = $clog2(POOL_PAGES + 1);
  localparam int STK_AW = PG_W + CNT_W;
  localparam int STK_D  = POOL_PAGES * SLOTS;

  localparam logic [1:0] CFG_POOL_BASE = 2'd0;
  localparam logic [1:0] CFG_PAGE_LIM  = 2'd1;
  localparam logic [1:0] CFG_MAX_OBJ   = 2'd2;

  typedef struct packed {
    logic             next_vld;
    logic [PG_W-1:0]  next_pg;
    logic [CLS_W-1:0] cls;
    logic [CNT_W-1:0] fc;
    logic [CNT_W-1:0] lw;
  } meta_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_META, S_STK, S_ADDR, S_FREE, S_DONE
  } state_t;

  // Header rounded up to the object size of class c.
  function automatic logic [31:0] hdr_of(input logic [CLS_W-1:0] c);
    logic [31:0] m;
    m = (32'd16 << c) - 32'd1;
    return (32'(HEADER_BYTES) + m) & ~m;
  endfunction

  // Objects per page of class c.
  function automatic logic [CNT_W-1:0] cap_of(input logic [CLS_W-1:0] c);
    logic [31:0] h;
    h = hdr_of(c);
    if (h >= 32'(PAGE_BYTES)) return '0;
    return CNT_W'((32'(PAGE_BYTES) - h) >> (4'(c) + 4'd4));
  endfunction

  state_t             state;
  req_type_t          req_type_r;
  logic [31:0]        req_size_r;
  logic [31:0]        req_addr_r;
  logic [31:0]        pool_base_r;
  logic [6:0]         page_limit_r;
  logic [11:0]        max_obj_r;
  logic [ISS_W-1:0]   issued;
  logic               head_vld [MAX_CLASSES];
  logic [PG_W-1:0]    head_pg  [MAX_CLASSES];
  logic [PG_W-1:0]    pg_r;
  logic [CNT_W-1:0]   obj_r;
  logic [PSH-1:0]     within_r;
  logic [31:0]        pend_addr;
  status_t            pend_status;
  logic               pend_owned;
  logic [31:0]        res_addr_r;
  status_t            res_status_r;
  logic               res_owned_r;

  meta_t              meta_mem [POOL_PAGES];
  meta_t              meta_q;
  logic               meta_we;
  logic [PG_W-1:0]    meta_wa;
  logic [PG_W-1:0]    meta_ra;
  meta_t              meta_wd;
  logic [CNT_W-1:0]   stk_mem [STK_D];
  logic [CNT_W-1:0]   stk_q;
  logic               stk_we;
  logic [STK_AW-1:0]  stk_wa;
  logic [STK_AW-1:0]  stk_ra;
  logic [CNT_W-1:0]   stk_wd;

  logic [CLS_W-1:0]   cls;
  logic               size_bad;
  logic [31:0]        frame_base;
  logic [31:0]        off;
  logic [31-PSH:0]    off_pg;
  logic               hit;
  logic               exhausted;
  logic [CNT_W-1:0]   cap_a;
  logic               fresh_go;
  logic [CNT_W-1:0]   pos;
  logic [CLS_W-1:0]   fcls;
  logic [31:0]        fhdr;
  logic [CNT_W-1:0]   fcap;
  logic [31:0]        in_page;
  logic [31:0]        free_obj;
  logic               free_go;

  soa_class_decode #(.NUM_CLASSES(NUM_CLASSES)) u_decode (
    .size         (req_size_r),
    .max_obj_size (max_obj_r),
    .cls          (cls),
    .bad          (size_bad)
  );

  // Address decode and page bookkeeping terms.
  assign frame_base = {pool_base_r[31:PSH], PSH'(0)};
  assign off        = req_addr_r - frame_base;
  assign off_pg     = off[31:PSH];
  assign hit        = (32'(off_pg) < 32'(issued)) && (32'(off_pg) < 32'(POOL_PAGES));
  assign exhausted  = (32'(issued) >= 32'(page_limit_r)) || (32'(issued) >= 32'(POOL_PAGES));
  assign cap_a      = cap_of(cls);
  assign fresh_go   = (state == S_DEC) && (req_type_r == REQ_ALLOC) && !size_bad &&
                      !head_vld[cls] && !exhausted && (cap_a != '0);
  assign pos        = meta_q.fc - 1'b1;

  assign fcls     = meta_q.cls;
  assign fhdr     = hdr_of(fcls);
  assign fcap     = cap_of(fcls);
  assign in_page  = 32'(within_r);
  assign free_obj = (in_page - fhdr) >> (4'(fcls) + 4'd4);
  assign free_go  = (state == S_FREE) && (in_page >= fhdr) &&
                    (free_obj < 32'(fcap)) && (meta_q.fc < fcap);

  assign meta_ra = (req_type_r == REQ_ALLOC) ? head_pg[cls] : off_pg[PG_W-1:0];
  assign stk_ra  = {pg_r, pos};

  // Write ports. Accesses never overlap on one entry: each request finishes
  // its reads before its own write and the next request starts afterwards.
  always_comb begin
    meta_we = 1'b0;
    meta_wa = pg_r;
    meta_wd = meta_q;
    stk_we  = 1'b0;
    stk_wa  = {pg_r, meta_q.fc};
    stk_wd  = free_obj[CNT_W-1:0];
    case (state)
      S_DEC: begin
        if (fresh_go) begin
          meta_we          = 1'b1;
          meta_wa          = issued[PG_W-1:0];
          meta_wd.next_vld = 1'b0;
          meta_wd.next_pg  = '0;
          meta_wd.cls      = cls;
          meta_wd.fc       = cap_a - 1'b1;
          meta_wd.lw       = cap_a - 1'b1;
        end
      end
      S_META: begin
        if (meta_q.fc != '0) begin
          meta_we    = 1'b1;
          meta_wd.fc = pos;
          if (pos < meta_q.lw) meta_wd.lw = pos;
        end
      end
      S_FREE: begin
        if (free_go) begin
          meta_we    = 1'b1;
          stk_we     = 1'b1;
          meta_wd.fc = meta_q.fc + 1'b1;
          if (meta_q.fc == '0) begin
            meta_wd.next_vld = head_vld[fcls];
            meta_wd.next_pg  = head_pg[fcls];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_q <= stk_mem[stk_ra];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base_r  <= 32'd1048576;
      page_limit_r <= 7'd64;
      max_obj_r    <= 12'd2048;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POOL_BASE: pool_base_r  <= cfg_data;
        CFG_PAGE_LIM:  page_limit_r <= cfg_data[6:0];
        CFG_MAX_OBJ:   max_obj_r    <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  // Request sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_CLASSES; i++) begin
        head_vld[i] <= 1'b0;
        head_pg[i]  <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_type_r  <= req_type_t'(req_type);
            req_size_r  <= req_size;
            req_addr_r  <= req_addr;
            pend_addr   <= '0;
            pend_status <= ST_OK;
            pend_owned  <= 1'b0;
            state       <= S_DEC;
          end
        end
        S_DEC: begin
          case (req_type_r)
            REQ_ALLOC: begin
              if (size_bad) begin
                pend_status <= ST_BAD_SIZE;
                state       <= S_DONE;
              end else if (head_vld[cls]) begin
                pg_r  <= head_pg[cls];
                state <= S_META;
              end else if (!fresh_go) begin
                pend_status <= ST_EXHAUSTED;
                state       <= S_DONE;
              end else begin
                // Claim the next frame; its first object is the top index.
                pg_r          <= issued[PG_W-1:0];
                obj_r         <= cap_a - 1'b1;
                issued        <= issued + 1'b1;
                head_vld[cls] <= (cap_a != CNT_W'(1));
                head_pg[cls]  <= issued[PG_W-1:0];
                state         <= S_ADDR;
              end
            end
            REQ_FREE, REQ_QUERY: begin
              if (!hit) begin
                pend_status <= ST_NOT_OWNED;
                state       <= S_DONE;
              end else begin
                pend_owned <= 1'b1;
                pg_r       <= off_pg[PG_W-1:0];
                within_r   <= off[PSH-1:0];
                state      <= (req_type_r == REQ_FREE) ? S_FREE : S_DONE;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_META: begin
          if (meta_q.fc == '0) begin
            pend_status <= ST_EXHAUSTED;
            state       <= S_DONE;
          end else begin
            if (pos == '0) begin
              head_vld[cls] <= meta_q.next_vld;
              head_pg[cls]  <= meta_q.next_pg;
            end
            if (pos < meta_q.lw) begin
              obj_r <= pos;
              state <= S_ADDR;
            end else begin
              state <= S_STK;
            end
          end
        end
        S_STK: begin
          obj_r <= stk_q;
          state <= S_ADDR;
        end
        S_ADDR: begin
          pend_addr <= frame_base + (32'(pg_r) << PSH) + hdr_of(cls) +
                       (32'(obj_r) << (4'(cls) + 4'd4));
          state     <= S_DONE;
        end
        S_FREE: begin
          // A page that was full goes back to the head of its partial list.
          if (free_go && (meta_q.fc == '0)) begin
            head_vld[fcls] <= 1'b1;
            head_pg[fcls]  <= pg_r;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            res_addr_r   <= pend_addr;
            res_status_r <= pend_status;
            res_owned_r  <= pend_owned;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall    = (state != S_IDLE);
  assign result_addr = res_addr_r;
  assign status      = res_status_r;
  assign owned       = res_owned_r;

  `ASSERT_IMP(a_issued_cap, 1'b1, 32'(issued) <= 32'(POOL_PAGES))
  `ASSERT_IMP(a_fail_zero_addr, out_valid && (res_status_r != ST_OK), res_addr_r == 32'd0)
  `ASSERT_IMP(a_stk_alloc_only, state == S_STK, req_type_r == REQ_ALLOC)
  `ASSERT_NXT(a_claim_step, fresh_go, issued == $past(issued) + 1'b1)

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for slab_object_allocator_unit: directed table, then random phases.
// Depends on soa_pkg and the allocator RTL; the expected results come from a local model.
`timescale 1ns / 1ps

module testbench;
  import soa_pkg::*;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_POOL_BASE = 2'd0;
  localparam logic [1:0] REG_PAGE_LIMIT = 2'd1;
  localparam logic [1:0] REG_MAX_SIZE = 2'd2;

  localparam int PAGE_SZ = 4096;
  localparam int FRAMES = 64;
  localparam int HDR = 20;
  localparam int SLOTS = PAGE_SZ / 16;
  localparam int NO_PAGE = -1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 140;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [31:0] req_size = '0;
  logic [31:0] req_addr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] result_addr;
  logic [1:0] status;
  logic owned;

  always #4 clk = ~clk;

  slab_object_allocator_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .req_size(req_size), .req_addr(req_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_addr(result_addr), .status(status), .owned(owned)
  );

  typedef struct {
    logic [31:0] addr;
    status_t st;
    logic own;
  } alloc_result_t;

  // One row of the directed table; typed rows carry a hand-read expectation.
  typedef struct {
    req_type_t kind;
    logic [31:0] size;
    logic [31:0] addr;
    bit typed;
    alloc_result_t want;
  } req_row_t;

  // Allocator image kept by the testbench.
  logic [31:0] base_reg;
  int limit_reg;
  int max_size_reg;
  int frames_claimed;
  int class_head [8];
  int frame_next [FRAMES];
  int frame_class [FRAMES];
  int frame_free [FRAMES];
  int frame_low [FRAMES];
  int frame_stack [FRAMES*SLOTS];

  alloc_result_t pending_results [$];
  logic [31:0] live_offsets [$];   // offsets from the frame base of objects handed out
  req_row_t dir_rows [$];

  int failures = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int grants = 0;
  int exhausted = 0;
  int frees_sent = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  function automatic logic [31:0] frame_base();
    return base_reg & ~32'(PAGE_SZ - 1);
  endfunction

  function automatic int hdr_of(input int sz);
    int m;
    m = sz - 1;
    return (HDR + m) & ~m;
  endfunction

  function automatic int objs_per_frame(input int sz);
    return (PAGE_SZ - hdr_of(sz)) / sz;
  endfunction

  function automatic void slab_reset();
    base_reg = 32'h0010_0000;
    limit_reg = 64;
    max_size_reg = 2048;
    frames_claimed = 0;
    foreach (class_head[i]) class_head[i] = NO_PAGE;
  endfunction

  function automatic void slab_config(input logic [1:0] idx, input logic [31:0] val);
    case (idx)
      REG_POOL_BASE: base_reg = val;
      REG_PAGE_LIMIT: limit_reg = val & 32'h7F;
      REG_MAX_SIZE: max_size_reg = val & 32'hFFF;
      default: ;
    endcase
  endfunction

  // Pop one object of the class that covers the size.
  function automatic alloc_result_t pool_take(input logic [31:0] size);
    alloc_result_t r;
    int c, sz, pg, pos, obj, lim;
    r = '{addr: '0, st: ST_OK, own: 1'b0};
    c = 8;
    if (size == 0 || size > max_size_reg) begin
      r.st = ST_BAD_SIZE;
      return r;
    end
    for (int i = 7; i >= 0; i--) if (size <= (16 << i)) c = i;
    if (c == 8) begin
      r.st = ST_BAD_SIZE;
      return r;
    end
    sz = 16 << c;
    pg = class_head[c];
    if (pg == NO_PAGE) begin
      lim = limit_reg < FRAMES ? limit_reg : FRAMES;
      if (frames_claimed >= lim) begin
        r.st = ST_EXHAUSTED;
        return r;
      end
      pg = frames_claimed++;
      frame_next[pg] = NO_PAGE;
      frame_class[pg] = c;
      frame_free[pg] = objs_per_frame(sz);
      frame_low[pg] = objs_per_frame(sz);
      class_head[c] = pg;
    end
    if (frame_free[pg] == 0) begin
      r.st = ST_EXHAUSTED;
      return r;
    end
    pos = frame_free[pg] - 1;
    if (pos < frame_low[pg]) begin
      obj = pos;
      frame_low[pg] = pos;
    end else begin
      obj = frame_stack[pg*SLOTS + pos];
    end
    frame_free[pg] = pos;
    if (pos == 0) class_head[c] = frame_next[pg];
    r.addr = frame_base() + 32'(pg * PAGE_SZ) + 32'(hdr_of(sz)) + 32'(obj * sz);
    return r;
  endfunction

  // Free or ownership query; only a free changes the image.
  function automatic alloc_result_t slab_release(input logic [31:0] addr, input bit just_ask);
    alloc_result_t r;
    logic [31:0] off;
    int pg, c, sz, in_page, obj, fc;
    r = '{addr: '0, st: ST_NOT_OWNED, own: 1'b0};
    off = addr - frame_base();
    if (off >= 32'(frames_claimed * PAGE_SZ)) return r;
    pg = int'(off >> 12);
    r.st = ST_OK;
    r.own = 1'b1;
    if (just_ask) return r;
    c = frame_class[pg];
    sz = 16 << c;
    in_page = int'(off[11:0]);
    if (in_page < hdr_of(sz)) return r;
    obj = (in_page - hdr_of(sz)) / sz;
    fc = frame_free[pg];
    if (obj >= objs_per_frame(sz) || fc >= objs_per_frame(sz)) return r;
    frame_stack[pg*SLOTS + fc] = obj;
    frame_free[pg] = fc + 1;
    if (fc == 0) begin
      frame_next[pg] = class_head[c];
      class_head[c] = pg;
    end
    return r;
  endfunction

  function automatic alloc_result_t slab_predict(input req_row_t q);
    alloc_result_t r;
    r = '{addr: '0, st: ST_OK, own: 1'b0};
    case (q.kind)
      REQ_ALLOC: begin
        r = pool_take(q.size);
        if (r.st == ST_OK) begin
          grants++;
          live_offsets.push_back(r.addr - frame_base());
        end
        if (r.st == ST_EXHAUSTED) exhausted++;
      end
      REQ_FREE: begin
        frees_sent++;
        r = slab_release(q.addr, 1'b0);
      end
      REQ_QUERY: r = slab_release(q.addr, 1'b1);
      default: ;
    endcase
    return r;
  endfunction

  task automatic row(input req_type_t k, input logic [31:0] sz, input logic [31:0] ad,
                     input bit typed = 0, input logic [31:0] ea = '0,
                     input status_t es = ST_OK, input logic eo = 1'b0);
    req_row_t q;
    q.kind = k;
    q.size = sz;
    q.addr = ad;
    q.typed = typed;
    q.want = '{addr: ea, st: es, own: eo};
    dir_rows.push_back(q);
  endtask

  // Present one request beat (called at a falling edge) and hold it until taken.
  task automatic send_beat(input req_row_t q);
    alloc_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = q.kind;
    req_size = q.size;
    req_addr = q.addr;
    do @(posedge clk); while (in_stall);
    r = slab_predict(q);
    pending_results.push_back(q.typed ? q.want : r);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    slab_config(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drain every expected beat, then let the block go idle.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic req_row_t random_request();
    req_row_t q;
    int pick, k, idx;
    q.typed = 0;
    q.want = '{addr: '0, st: ST_OK, own: 1'b0};
    q.size = $urandom();
    q.addr = $urandom();
    pick = $urandom_range(0, 99);
    if (pick >= 45 && pick < 75 && live_offsets.size() == 0) pick = 0;
    if (pick < 40) begin
      // well-formed alloc, size drawn up to a randomly chosen class size
      q.kind = REQ_ALLOC;
      k = $urandom_range(0, 7);
      q.size = $urandom_range(1, 16 << k);
    end else if (pick < 45) begin
      q.kind = REQ_ALLOC;
      case ($urandom_range(0, 3))
        0: q.size = 0;
        1: q.size = $urandom_range(2049, 4096);
        default: ;
      endcase
    end else if (pick < 75) begin
      // free an object we own; sometimes keep it live for a double free
      q.kind = REQ_FREE;
      idx = $urandom_range(0, live_offsets.size() - 1);
      q.addr = frame_base() + live_offsets[idx] + ($urandom_range(0, 3) == 0 ?
               32'($urandom_range(0, 15)) : 32'd0);
      if ($urandom_range(0, 9) != 0) live_offsets.delete(idx);
    end else if (pick < 85) begin
      q.kind = REQ_FREE;
      if (pick < 82) q.addr = frame_base() + 32'($urandom_range(0, 70 * PAGE_SZ));
    end else if (pick < 96) begin
      q.kind = REQ_QUERY;
      if (pick < 93) q.addr = frame_base() + 32'($urandom_range(0, 70 * PAGE_SZ));
    end else begin
      q.kind = REQ_NOP;
    end
    return q;
  endfunction

  // Result checker: every taken output beat must match the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat addr=%h status=%0d owned=%b",
                 $time, result_addr, status, owned);
        failures++;
      end else begin
        w = pending_results.pop_front();
        beats_checked++;
        if (result_addr !== w.addr) begin
          $display("%0t: result_addr expected %h actual %h", $time, w.addr, result_addr);
          failures++;
        end
        if (status !== w.st) begin
          $display("%0t: status expected %0d actual %0d", $time, w.st, status);
          failures++;
        end
        if (owned !== w.own) begin
          $display("%0t: owned expected %b actual %b", $time, w.own, owned);
          failures++;
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts of random length.
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Watchdog: give up on a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int lim;
    slab_reset();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed part, defaults after reset: base 0x100000, 64 frames, max 2048.
    row(REQ_ALLOC, 32'd0, 32'd0, 1, 32'd0, ST_BAD_SIZE);
    row(REQ_ALLOC, 32'd2049, 32'd0, 1, 32'd0, ST_BAD_SIZE);
    row(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, ST_BAD_SIZE);
    row(REQ_QUERY, 32'd0, 32'h0010_0000, 1, 32'd0, ST_NOT_OWNED, 1'b0);
    row(REQ_FREE, 32'd0, 32'd0, 1, 32'd0, ST_NOT_OWNED, 1'b0);
    row(REQ_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, ST_OK, 1'b0);
    // fresh frame pops highest object first: header 32, 254 objects of 16
    row(REQ_ALLOC, 32'd16, 32'd0, 1, 32'h0010_0FF0, ST_OK);
    row(REQ_ALLOC, 32'd2048, 32'd0, 1, 32'h0010_1800, ST_OK);
    row(REQ_ALLOC, 32'd1, 32'd0, 1, 32'h0010_0FE0, ST_OK);
    row(REQ_QUERY, 32'd0, 32'h0010_0000, 1, 32'd0, ST_OK, 1'b1);
    row(REQ_QUERY, 32'd0, 32'h0010_2000, 1, 32'd0, ST_NOT_OWNED, 1'b0);
    row(REQ_FREE, 32'd0, 32'h0010_0000, 1, 32'd0, ST_OK, 1'b1);   // header pointer
    row(REQ_FREE, 32'd0, 32'h0010_0FF0, 0);
    row(REQ_FREE, 32'd0, 32'h0010_0FE5, 0);                       // unaligned
    row(REQ_FREE, 32'd0, 32'h0010_0FE0, 0);                       // double free
    row(REQ_ALLOC, 32'd9, 32'd0, 0);
    row(REQ_ALLOC, 32'd2000, 32'd0, 0);                           // claims a new frame
    row(REQ_FREE, 32'd0, 32'h0010_1800, 0);                       // full frame relinked
    row(REQ_FREE, 32'd0, 32'h0010_1000, 0);                       // header of 2048 frame
    row(REQ_FREE, 32'd0, 32'h0010_1900, 0);                       // overfull free
    row(REQ_ALLOC, 32'd2048, 32'd0, 0);
    for (int k = 1; k < 7; k++) row(REQ_ALLOC, 32'((16 << k) - 1) + 32'd2, 32'd0, 0);
    foreach (dir_rows[i]) send_beat(dir_rows[i]);
    drain();

    // Random phases, each under a different register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_POOL_BASE, 32'h0000_0000);
          write_reg(REG_PAGE_LIMIT, 32'd64);
          write_reg(REG_MAX_SIZE, 32'd2048);
        end
        1: begin
          // top of the address space: frames wrap past zero
          write_reg(REG_POOL_BASE, 32'hFFFF_F000);
          write_reg(REG_MAX_SIZE, 32'd1);
        end
        2: begin
          // unaligned base, limit above the pool, max above the largest class
          write_reg(REG_POOL_BASE, 32'h1234_5678);
          write_reg(REG_PAGE_LIMIT, 32'd127);
          write_reg(REG_MAX_SIZE, 32'd4095);
        end
        3: begin
          lim = frames_claimed + 2;
          write_reg(REG_PAGE_LIMIT, 32'(lim));
          write_reg(REG_MAX_SIZE, 32'd100);
        end
        4: begin
          write_reg(REG_PAGE_LIMIT, 32'd0);
          write_reg(REG_MAX_SIZE, 32'd2048);
        end
        default: begin
          // last stretch: no idling on either side
          quiet = 1'b1;
          write_reg(REG_POOL_BASE, 32'h0010_0000);
          write_reg(REG_PAGE_LIMIT, 32'd64);
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_beat(random_request());
      drain();
    end

    repeat (20) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected result beats never arrived", pending_results.size());
      failures += pending_results.size();
    end
    $display("Coverage: %0d requests, %0d result beats checked, %0d frames claimed",
             beats_sent, beats_checked, frames_claimed);
    $display("          %0d allocs granted, %0d pool-exhausted, %0d frees, 6 register settings",
             grants, exhausted, frees_sent);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
